// ===== rtl/vdf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vdf_pkg
// Shared types, constants and codes of the music volume duck and fade block.
// ----------------------------------------------------------------------------
package vdf_pkg;

    localparam int VOL_W      = 8;
    localparam int PCT_W      = 7;
    localparam int TICK_W     = 16;
    localparam int STEP_W     = VOL_W + 1;       // signed ramp step, -256..255
    localparam int CFG_IDX_W  = 8;
    localparam int DIV_W      = 16;              // serial divider word
    localparam int DIV_CNT_W  = $clog2(DIV_W);

    localparam int RAMP_DIV   = 8;
    localparam int VOL_MAX    = 255;
    localparam int PCT_MAX    = 100;

    localparam logic [CFG_IDX_W-1:0] REG_DIM_FACTOR = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_EFF_FACTOR = CFG_IDX_W'(1);

    typedef enum logic [2:0] {
        MODE_DIM        = 3'd0,
        MODE_UNDIM      = 3'd1,
        MODE_DIM_TICK   = 3'd2,
        MODE_FADE_START = 3'd3,
        MODE_FADE_TICK  = 3'd4,
        MODE_SET_VOLUME = 3'd5,
        MODE_SCENE      = 3'd6
    } t_mode;

    typedef struct packed {
        t_mode              mode;
        logic               script_request;
        logic               playing;
        logic [PCT_W-1:0]   volume_percent;
        logic [TICK_W-1:0]  fade_ticks;
    } t_event;

    typedef struct packed {
        logic [VOL_W-1:0]   channel_volume;
        logic               channel_update;
        logic [VOL_W-1:0]   effects_volume;
        logic               effects_update;
        logic               is_dimmed;
        logic               is_script_dimmed;
    } t_result;

    typedef struct packed {
        logic                  valid;
        logic [CFG_IDX_W-1:0]  index;
        logic [VOL_W-1:0]      data;
    } t_cfg_wr;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DIV_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_W-1:0]  quotient;
    } t_div_rsp;

endpackage
`default_nettype wire

// ===== rtl/vdf_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vdf_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vdf_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire vdf_pkg::t_div_req i_req,
    output vdf_pkg::t_div_rsp      o_rsp
);
    import vdf_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]     r_rem;
    logic [DIV_W-1:0]     r_quo;
    logic [DIV_W-1:0]     r_dvs;

    logic [DIV_W:0]       rem_sh;
    logic [DIV_W:0]       trial;

    assign rem_sh = {r_rem, r_quo[DIV_W-1]};
    assign trial  = rem_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_req.dividend;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                // dividend bits shift out of the top as quotient bits shift in
                if (!trial[DIV_W]) begin
                    r_rem <= trial[DIV_W-1:0];
                    r_quo <= {r_quo[DIV_W-2:0], 1'b1};
                end else begin
                    r_rem <= rem_sh[DIV_W-1:0];
                    r_quo <= {r_quo[DIV_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule
`default_nettype wire

// ===== rtl/vdf_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vdf_core
// Volume state and event sequencer; hands every division to the serial divider.
// ----------------------------------------------------------------------------
module vdf_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire vdf_pkg::t_cfg_wr  i_cfg,
    input  wire logic              i_evt_valid,
    input  wire vdf_pkg::t_event   i_evt,
    output logic                   o_evt_ready,
    output logic                   o_res_valid,
    output vdf_pkg::t_result       o_res,
    input  wire logic              i_res_ready,
    output vdf_pkg::t_div_req      o_div_req,
    input  wire vdf_pkg::t_div_rsp i_div_rsp
);
    import vdf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIM_Q,
        S_RAMP,
        S_EFF,
        S_FADE_Q,
        S_FADE_STEP,
        S_SETVOL,
        S_DONE
    } t_state;

    t_state              r_state;
    t_mode               r_mode;
    logic [TICK_W-1:0]   r_ticks;
    logic                r_neg;

    logic [VOL_W-1:0]    r_df;
    logic [VOL_W-1:0]    r_edf;
    logic [VOL_W-1:0]    r_uv;
    logic                r_dim;
    logic                r_sdim;
    logic [VOL_W-1:0]    r_dt;
    logic signed [STEP_W-1:0] r_step;
    logic [VOL_W-1:0]    r_pos;
    logic [VOL_W-1:0]    r_flvl;
    logic [VOL_W-1:0]    r_fstep;

    logic [VOL_W-1:0]    r_chan;
    logic                r_chan_up;
    logic [VOL_W-1:0]    r_eff;
    logic                r_eff_up;
    t_div_req            r_dreq;

    logic                active;
    logic [TICK_W-1:0]   ticks1;
    logic signed [STEP_W-1:0] undim_diff;
    logic [VOL_W-1:0]    undim_abs;
    logic signed [STEP_W:0] tick_sum;
    logic [VOL_W:0]      fade_sub;
    logic [VOL_W-1:0]    fade_next;
    logic [PCT_W-1:0]    pct_sat;
    logic [DIV_W-1:0]    pct_scaled;
    logic [VOL_W-1:0]    q8;
    logic [VOL_W-1:0]    dim_lvl;
    logic signed [STEP_W-1:0] q_step;

    assign active     = (r_uv != '0) && i_evt.playing;
    assign ticks1     = (i_evt.fade_ticks == '0) ? TICK_W'(1) : i_evt.fade_ticks;
    assign undim_diff = $signed({1'b0, r_uv}) - $signed({1'b0, r_dt});
    assign undim_abs  = undim_diff[STEP_W-1] ? VOL_W'(-undim_diff) : undim_diff[VOL_W-1:0];
    assign tick_sum   = $signed({2'b00, r_pos}) + $signed({r_step[STEP_W-1], r_step});
    assign fade_sub   = {1'b0, r_flvl} - {1'b0, r_fstep};
    assign fade_next  = fade_sub[VOL_W] ? '0 : fade_sub[VOL_W-1:0];
    assign pct_sat    = (i_evt.volume_percent > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX)
                                                                 : i_evt.volume_percent;
    // pct * 255 as (pct << 8) - pct
    assign pct_scaled = DIV_W'({pct_sat, 8'h00}) - DIV_W'(pct_sat);
    assign q8         = i_div_rsp.quotient[VOL_W-1:0];
    assign dim_lvl    = r_uv - q8;
    assign q_step     = $signed({1'b0, q8});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_df         <= '0;
            r_edf        <= '0;
            r_uv         <= VOL_W'(VOL_MAX);
            r_dim        <= 1'b0;
            r_sdim       <= 1'b0;
            r_dt         <= '0;
            r_step       <= '0;
            r_pos        <= '0;
            r_flvl       <= '0;
            r_fstep      <= '0;
            r_dreq.start <= 1'b0;
        end else begin
            r_dreq.start <= 1'b0;

            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_DIM_FACTOR: r_df  <= i_cfg.data;
                    REG_EFF_FACTOR: r_edf <= i_cfg.data;
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (i_evt_valid) begin
                        r_mode    <= i_evt.mode;
                        r_ticks   <= ticks1;
                        r_chan    <= '0;
                        r_chan_up <= 1'b0;
                        r_eff     <= '0;
                        r_eff_up  <= 1'b0;
                        r_state   <= S_DONE;
                        case (i_evt.mode)
                            MODE_DIM: begin
                                if (!r_dim && active && r_df != '0) begin
                                    r_dim <= 1'b1;
                                    if (i_evt.script_request) begin
                                        r_sdim <= 1'b1;
                                    end
                                    r_dreq.start    <= 1'b1;
                                    r_dreq.dividend <= DIV_W'(r_uv);
                                    r_dreq.divisor  <= DIV_W'(r_df);
                                    r_state         <= S_DIM_Q;
                                end
                            end
                            MODE_UNDIM: begin
                                if (r_dim && !(r_sdim && !i_evt.script_request)) begin
                                    r_dim  <= 1'b0;
                                    r_sdim <= 1'b0;
                                    if (active) begin
                                        if (r_step == '0) begin
                                            r_pos <= r_dt;
                                        end
                                        r_neg           <= undim_diff[STEP_W-1];
                                        r_eff           <= VOL_W'(VOL_MAX);
                                        r_eff_up        <= 1'b1;
                                        r_dreq.start    <= 1'b1;
                                        r_dreq.dividend <= DIV_W'(undim_abs);
                                        r_dreq.divisor  <= DIV_W'(RAMP_DIV);
                                        r_state         <= S_RAMP;
                                    end
                                end
                            end
                            MODE_DIM_TICK: begin
                                if (r_step != '0) begin
                                    r_chan_up <= 1'b1;
                                    // clamp to user volume first, then to the duck target
                                    if (tick_sum >= $signed({2'b00, r_uv})) begin
                                        r_pos  <= r_uv;
                                        r_chan <= r_uv;
                                        r_step <= '0;
                                    end else if (tick_sum <= $signed({2'b00, r_dt})) begin
                                        r_pos  <= r_dt;
                                        r_chan <= r_dt;
                                        r_step <= '0;
                                    end else begin
                                        r_pos  <= tick_sum[VOL_W-1:0];
                                        r_chan <= tick_sum[VOL_W-1:0];
                                    end
                                end
                            end
                            MODE_FADE_START: begin
                                if (active) begin
                                    r_dreq.start <= 1'b1;
                                    if (r_dim && r_df != '0) begin
                                        r_dim           <= 1'b0;
                                        r_dreq.dividend <= DIV_W'(r_uv);
                                        r_dreq.divisor  <= DIV_W'(r_df);
                                        r_state         <= S_FADE_Q;
                                    end else begin
                                        r_dim           <= 1'b0;
                                        r_flvl          <= r_uv;
                                        r_dreq.dividend <= DIV_W'(r_uv);
                                        r_dreq.divisor  <= DIV_W'(ticks1);
                                        r_state         <= S_FADE_STEP;
                                    end
                                end
                            end
                            MODE_FADE_TICK: begin
                                if (active) begin
                                    r_flvl    <= fade_next;
                                    r_chan    <= fade_next;
                                    r_chan_up <= 1'b1;
                                end
                            end
                            MODE_SET_VOLUME: begin
                                r_dim           <= 1'b0;
                                r_dreq.start    <= 1'b1;
                                r_dreq.dividend <= pct_scaled;
                                r_dreq.divisor  <= DIV_W'(PCT_MAX);
                                r_state         <= S_SETVOL;
                            end
                            MODE_SCENE: begin
                                r_dim     <= 1'b0;
                                r_sdim    <= 1'b0;
                                r_step    <= '0;
                                r_uv      <= VOL_W'(VOL_MAX);
                                r_chan    <= VOL_W'(VOL_MAX);
                                r_chan_up <= 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
                S_DIM_Q: begin
                    if (i_div_rsp.done) begin
                        // duck target is volume less volume/factor; step is -(q / divisor)
                        r_dt <= dim_lvl;
                        if (r_step == '0) begin
                            r_pos <= r_uv;
                        end
                        r_neg           <= 1'b1;
                        r_dreq.start    <= 1'b1;
                        r_dreq.dividend <= i_div_rsp.quotient;
                        r_dreq.divisor  <= DIV_W'(RAMP_DIV);
                        r_state         <= S_RAMP;
                    end
                end
                S_RAMP: begin
                    if (i_div_rsp.done) begin
                        r_step <= r_neg ? -q_step : q_step;
                        if (r_mode == MODE_DIM && r_edf != '0) begin
                            r_dreq.start    <= 1'b1;
                            r_dreq.dividend <= DIV_W'(VOL_MAX);
                            r_dreq.divisor  <= DIV_W'(r_edf);
                            r_state         <= S_EFF;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_EFF: begin
                    if (i_div_rsp.done) begin
                        r_eff    <= VOL_W'(VOL_MAX) - q8;
                        r_eff_up <= 1'b1;
                        r_state  <= S_DONE;
                    end
                end
                S_FADE_Q: begin
                    if (i_div_rsp.done) begin
                        r_flvl          <= dim_lvl;
                        r_dreq.start    <= 1'b1;
                        r_dreq.dividend <= DIV_W'(dim_lvl);
                        r_dreq.divisor  <= DIV_W'(r_ticks);
                        r_state         <= S_FADE_STEP;
                    end
                end
                S_FADE_STEP: begin
                    if (i_div_rsp.done) begin
                        // step never exceeds the level here, so no floor needed
                        r_fstep   <= q8;
                        r_flvl    <= r_flvl - q8;
                        r_chan    <= r_flvl - q8;
                        r_chan_up <= 1'b1;
                        r_state   <= S_DONE;
                    end
                end
                S_SETVOL: begin
                    if (i_div_rsp.done) begin
                        r_uv      <= q8;
                        r_chan    <= q8;
                        r_chan_up <= 1'b1;
                        r_state   <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_evt_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_div_req   = r_dreq;

    assign o_res.channel_volume   = r_chan;
    assign o_res.channel_update   = r_chan_up;
    assign o_res.effects_volume   = r_eff;
    assign o_res.effects_update   = r_eff_up;
    assign o_res.is_dimmed        = r_dim;
    assign o_res.is_script_dimmed = r_sdim;

endmodule
`default_nettype wire

// ===== rtl/volume_duck_and_fade_ramp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ticks, scene reset and refused events need no division; every division goes through
//   the 16-step serial divider (one quotient bit per cycle), and dim takes up to three
//   divisions, fade start up to two, undim and set volume one each
// throughput: one item in flight; the next is taken once the result enters the output register
// reset: synchronous active low; full user volume, no dimming, no ramp, factors 0
// ----------------------------------------------------------------------------
// volume_duck_and_fade_ramp
// Music channel volume controller with duck ramp and fade out, stream ports.
// ----------------------------------------------------------------------------
module volume_duck_and_fade_ramp (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [vdf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [vdf_pkg::VOL_W-1:0]     i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // script_request, playing, volume_percent[6:0], fade_ticks[15:0], zero pad
    input  wire logic [31:0] s_axis_tdata,
    // mode[2:0]
    input  wire logic [2:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // channel_volume[7:0], channel_update, effects_volume[7:0], effects_update,
    // is_dimmed, is_script_dimmed, zero pad
    output logic [23:0]      m_axis_tdata
);
    import vdf_pkg::*;

    t_cfg_wr  cfg;
    t_event   evt;
    t_result  res;
    t_div_req dreq;
    t_div_rsp drsp;
    logic     res_valid;
    logic     res_ready;

    logic        r_m_valid;
    logic [23:0] r_m_data;

    assign cfg.valid = i_cfg_valid;
    assign cfg.index = i_cfg_index;
    assign cfg.data  = i_cfg_data;
    assign o_cfg_ready = 1'b1;

    assign evt.mode           = t_mode'(s_axis_tuser);
    assign evt.script_request = s_axis_tdata[0];
    assign evt.playing        = s_axis_tdata[1];
    assign evt.volume_percent = s_axis_tdata[8:2];
    assign evt.fade_ticks     = s_axis_tdata[24:9];

    assign res_ready = !r_m_valid || m_axis_tready;

    vdf_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_evt_valid (s_axis_tvalid),
        .i_evt       (evt),
        .o_evt_ready (s_axis_tready),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready),
        .o_div_req   (dreq),
        .i_div_rsp   (drsp)
    );

    vdf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (dreq),
        .o_rsp   (drsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else begin
            if (res_valid && res_ready) begin
                r_m_valid <= 1'b1;
                r_m_data  <= {4'b0000, res.is_script_dimmed, res.is_dimmed,
                              res.effects_update, res.effects_volume,
                              res.channel_update, res.channel_volume};
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule
`default_nettype wire

// ===== rtl/vdf_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vdf_checker
// Port-level checks of the volume duck and fade block, bound to the top level.
// ----------------------------------------------------------------------------
module vdf_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [23:0] m_axis_tdata
);

    // a result never shows right out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // one item at a time: taking an item closes the input side
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second item taken while one in flight");

    a_chan_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[8] || (m_axis_tdata[7:0] == 8'd0)))
        else $error("channel volume without update flag");

    a_eff_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[17] || (m_axis_tdata[16:9] == 8'd0)))
        else $error("effects volume without update flag");

endmodule

bind volume_duck_and_fade_ramp vdf_checker u_vdf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
